/* hw/rtl/khps_pkg.sv */
// ---------------------------------------------------------------------------
// khps_pkg
// Shared widths, constants, state encoding and the controller/datapath
// command and status bundles of the key hash partition selector.
// ---------------------------------------------------------------------------
package khps_pkg;

   localparam int unsigned KEY_BYTE_WIDTH         = 8;
   localparam int unsigned HASH_WIDTH             = 32;
   localparam int unsigned MASK_WIDTH             = 64;
   localparam int unsigned PARTITION_WIDTH        = 6;
   localparam int unsigned COUNT_WIDTH            = 7;
   localparam int unsigned DIV_CNT_WIDTH          = 5;
   localparam int unsigned CSR_INDEX_WIDTH        = 2;
   localparam int unsigned CSR_DATA_WIDTH         = 7;
   localparam int unsigned MAX_PARTITIONS_DEFAULT = 64;
   localparam int unsigned HASH_SHIFT             = 5;

   localparam logic [HASH_WIDTH-1:0] HASH_SEED = 32'd5381;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PARTITION_COUNT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHAR_IS_SIGNED  = 2'd1;

   localparam logic [COUNT_WIDTH-1:0] COUNT_RESET  = 7'd1;
   localparam logic                   SIGNED_RESET = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_PROBE,
      ST_DONE
   } khps_state_type;

   typedef struct packed {
      logic hash_upd;     // input transfer: fold in the byte
      logic sel_start;    // transfer carries the last byte: start selection
      logic div_step;     // one restoring-division bit
      logic probe_step;   // advance probe position
      logic rsp_load;     // move selection into the output register
   } khps_cmd_type;

   typedef struct packed {
      logic div_last;     // final quotient bit this cycle
      logic probe_hit;    // current position available, or probes exhausted
      logic rsp_free;     // output register can take a new result
   } khps_status_type;

endpackage

/* hw/rtl/khps_ctrl.sv */
// ---------------------------------------------------------------------------
// khps_ctrl
// Sequencer: takes key bytes in idle, then runs the modulo divide, the
// forward probe and the hand-off to the output register.
// ---------------------------------------------------------------------------
module khps_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_last_byte,
   output khps_pkg::khps_cmd_type   cmd,
   input  khps_pkg::khps_status_type status
);

   khps_pkg::khps_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= khps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         khps_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.hash_upd = 1'b1;
               if (req_last_byte) begin
                  cmd.sel_start = 1'b1;
                  state_in      = khps_pkg::ST_DIV;
               end
            end
         end
         khps_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = khps_pkg::ST_PROBE;
            end
         end
         khps_pkg::ST_PROBE: begin
            if (status.probe_hit) begin
               state_in = khps_pkg::ST_DONE;
            end else begin
               cmd.probe_step = 1'b1;
            end
         end
         khps_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = khps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = khps_pkg::ST_IDLE;
         end
      endcase
   end

   a_div_stays: assert property (@(posedge clock) disable iff (reset)
      (state_ff == khps_pkg::ST_DIV && !status.div_last) |=> state_ff == khps_pkg::ST_DIV)
      else $error("divide left early");

   a_hit_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == khps_pkg::ST_PROBE && status.probe_hit) |=> state_ff == khps_pkg::ST_DONE)
      else $error("probe hit did not finish");

   a_start_from_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.sel_start |=> state_ff == khps_pkg::ST_DIV)
      else $error("selection start lost");

endmodule

/* hw/rtl/khps_datapath.sv */
// ---------------------------------------------------------------------------
// khps_datapath
// Hash accumulator, configuration registers, bit-serial modulo, probe
// position/countdown and the result register.
// ---------------------------------------------------------------------------
module khps_datapath #(
   parameter int unsigned MAX_PARTITIONS = khps_pkg::MAX_PARTITIONS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_wr_en,
   input  logic [khps_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [khps_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata,
   input  logic [khps_pkg::KEY_BYTE_WIDTH-1:0]      req_key_byte,
   input  logic                                     req_byte_present,
   input  logic [khps_pkg::MASK_WIDTH-1:0]          req_available_mask,
   input  khps_pkg::khps_cmd_type                   cmd,
   output khps_pkg::khps_status_type                status,
   input  logic                                     rsp_ready,
   output logic                                     rsp_valid,
   output logic [khps_pkg::PARTITION_WIDTH-1:0]     rsp_partition,
   output logic [khps_pkg::HASH_WIDTH-1:0]          rsp_key_hash
);

   localparam int unsigned CW = khps_pkg::COUNT_WIDTH;
   localparam int unsigned HW = khps_pkg::HASH_WIDTH;
   localparam int unsigned PW = khps_pkg::PARTITION_WIDTH;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_PARTITIONS);

   logic [CW-1:0] count_ff, count_in;
   logic          signed_ff, signed_in;
   logic [CW-1:0] eff_count;

   logic [HW-1:0] hash_ff, hash_in;
   logic [HW-1:0] addend, hash_upd_val, hash_final;

   logic [HW-1:0]                        dividend_ff, dividend_in;
   logic [CW-1:0]                        rem_ff, rem_in;
   logic [khps_pkg::DIV_CNT_WIDTH-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [PW-1:0]                        left_ff, left_in;
   logic [khps_pkg::MASK_WIDTH-1:0]      mask_ff, mask_in;
   logic [HW-1:0]                        hash_out_ff, hash_out_in;
   logic [CW-1:0]                        rem_shift, target_inc;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] rsp_part_ff, rsp_part_in;
   logic [HW-1:0] rsp_hash_ff, rsp_hash_in;

   // ---- configuration ----
   always_comb begin
      count_in  = count_ff;
      signed_in = signed_ff;
      if (csr_wr_en) begin
         case (csr_index)
            khps_pkg::CSR_PARTITION_COUNT: count_in  = csr_wdata[CW-1:0];
            khps_pkg::CSR_CHAR_IS_SIGNED:  signed_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (count_ff == '0) begin
         eff_count = CW'(1);
      end else if (count_ff > MAX_COUNT) begin
         eff_count = MAX_COUNT;
      end else begin
         eff_count = count_ff;
      end
   end

   // ---- hash ----
   assign addend = {{(HW-khps_pkg::KEY_BYTE_WIDTH){signed_ff & req_key_byte[7]}},
                    req_key_byte};
   assign hash_upd_val = (hash_ff << khps_pkg::HASH_SHIFT) + hash_ff + addend;
   assign hash_final   = req_byte_present ? hash_upd_val : hash_ff;

   always_comb begin
      hash_in = hash_ff;
      if (cmd.sel_start) begin
         hash_in = khps_pkg::HASH_SEED;
      end else if (cmd.hash_upd) begin
         hash_in = hash_final;
      end
   end

   // ---- modulo (restoring, one bit per cycle) then probe ----
   // rem_ff becomes the probe position once the last quotient bit is done.
   assign rem_shift  = {rem_ff[CW-2:0], dividend_ff[HW-1]};
   assign target_inc = rem_ff + CW'(1);

   always_comb begin
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      bit_cnt_in  = bit_cnt_ff;
      left_in     = left_ff;
      mask_in     = mask_ff;
      hash_out_in = hash_out_ff;
      if (cmd.sel_start) begin
         dividend_in = hash_final;
         rem_in      = '0;
         bit_cnt_in  = '0;
         left_in     = PW'(eff_count - CW'(1));
         mask_in     = req_available_mask;
         hash_out_in = hash_final;
      end else if (cmd.div_step) begin
         dividend_in = dividend_ff << 1;
         bit_cnt_in  = bit_cnt_ff + 1'b1;
         rem_in      = (rem_shift >= eff_count) ? rem_shift - eff_count : rem_shift;
      end else if (cmd.probe_step) begin
         rem_in  = (target_inc == eff_count) ? '0 : target_inc;
         left_in = left_ff - 1'b1;
      end
   end

   assign status.div_last  = (bit_cnt_ff == '1);
   assign status.probe_hit = (left_ff == '0) || mask_ff[rem_ff[PW-1:0]];
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   // ---- result register ----
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_part_in  = rsp_part_ff;
      rsp_hash_in  = rsp_hash_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_part_in  = rem_ff[PW-1:0];
         rsp_hash_in  = hash_out_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= khps_pkg::COUNT_RESET;
         signed_ff    <= khps_pkg::SIGNED_RESET;
         hash_ff      <= khps_pkg::HASH_SEED;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         signed_ff    <= signed_in;
         hash_ff      <= hash_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      left_ff     <= left_in;
      mask_ff     <= mask_in;
      hash_out_ff <= hash_out_in;
      rsp_part_ff <= rsp_part_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_partition = rsp_part_ff;
   assign rsp_key_hash  = rsp_hash_ff;

   a_probe_range: assert property (@(posedge clock) disable iff (reset)
      cmd.probe_step |-> (rem_ff < eff_count) && (left_ff != '0))
      else $error("probe position out of range");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before transfer");

   a_seed_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.sel_start |=> hash_ff == khps_pkg::HASH_SEED)
      else $error("hash not reseeded after key");

endmodule

/* hw/rtl/key_hash_partition_select.sv */
// ---------------------------------------------------------------------------
// key_hash_partition_select
// Key hash and partition selection: djb2-style hash of the key bytes, modulo
// the partition count, then a forward probe for an available partition.
// ---------------------------------------------------------------------------
// Bytes are fed last-to-first, one transfer each; a byte that is not the
// last of its key is taken while idle, back to back. The transfer marked
// last starts selection and the input is held off until it ends: the
// bit-serial modulo, then probing (one partition per cycle, up to count-1
// probes), then the hand-off of the result to the output register. A
// finished result waits in the output register without blocking the next
// key's bytes, but the next key end holds in its hand-off state until
// that result transfers.
// Write partition_count (index 0) and char_is_signed (index 1) only while
// no key end is in flight.
module key_hash_partition_select #(
   parameter int unsigned MAX_PARTITIONS = khps_pkg::MAX_PARTITIONS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [khps_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [khps_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [khps_pkg::KEY_BYTE_WIDTH-1:0]   req_key_byte,
   input  logic                                  req_byte_present,
   input  logic                                  req_last_byte,
   input  logic [khps_pkg::MASK_WIDTH-1:0]       req_available_mask,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [khps_pkg::PARTITION_WIDTH-1:0]  rsp_partition,
   output logic [khps_pkg::HASH_WIDTH-1:0]       rsp_key_hash
);

   khps_pkg::khps_cmd_type    cmd;
   khps_pkg::khps_status_type status;

   khps_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_last_byte (req_last_byte),
      .cmd           (cmd),
      .status        (status)
   );

   khps_datapath #(
      .MAX_PARTITIONS (MAX_PARTITIONS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_key_byte       (req_key_byte),
      .req_byte_present   (req_byte_present),
      .req_available_mask (req_available_mask),
      .cmd                (cmd),
      .status             (status),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_partition      (rsp_partition),
      .rsp_key_hash       (rsp_key_hash)
   );

endmodule
